[rtl/core/cpls_pkg.sv]
// Package: types, codes and per-state attribute table of the charge port lock sequencer.
package cpls_pkg;

  localparam int unsigned STATE_COUNT = 13;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned TIMER_W     = 8;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [TIMER_W-1:0] TIMER_MAX            = 8'd255;
  localparam logic [TIMER_W-1:0] MOTOR_RUN_RESET      = 8'd6;
  localparam logic [TIMER_W-1:0] RELEASE_WAIT_RESET   = 8'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_RUN    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_WAIT = 4'd1;

  localparam logic [1:0] SENSE_LOCKED   = 2'd1;
  localparam logic [1:0] SENSE_UNLOCKED = 2'd2;

  // One-hot state vector; bit position equals the reported state code.
  typedef enum logic [STATE_COUNT-1:0] {
    ST_POWER_ON        = 13'h0001,
    ST_IDLE            = 13'h0002,
    ST_PLUG_DETECT     = 13'h0004,
    ST_LOCKING         = 13'h0008,
    ST_LOCK_CHECK      = 13'h0010,
    ST_CHARGING        = 13'h0020,
    ST_POWER_LOST      = 13'h0040,
    ST_UNLOCKING       = 13'h0080,
    ST_UNLOCK_WAIT     = 13'h0100,
    ST_UNLOCKED        = 13'h0200,
    ST_ERR_UNLOCK      = 13'h0400,
    ST_ERR_UNLOCK_WAIT = 13'h0800,
    ST_ERR_UNLOCKED    = 13'h1000
  } state_t;

  typedef enum logic [1:0] {
    TO_NONE    = 2'd0,
    TO_MOTOR   = 2'd1,
    TO_RELEASE = 2'd2
  } to_kind_t;

  typedef struct packed {
    to_kind_t to_kind;
    logic     inhibit;
    logic     motor_close;
    logic     motor_open;
    logic     charge;
    logic     red;
    logic     yellow;
    logic     green;
    logic     flash;
  } attr_t;

  typedef struct packed {
    logic       tick;
    logic       has_cp;
    logic       has_pp;
    logic [1:0] lock_sense;
    logic       unlock_pressed;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0] state_code;
    logic              changed;
    logic              inhibit_traction;
    logic              motor_close;
    logic              motor_open;
    logic              charge_enable;
    logic              lamp_red;
    logic              lamp_yellow;
    logic              lamp_green;
    logic              lamp_flash;
  } result_t;

  function automatic attr_t attr_of(state_t s);
    attr_t a;
    case (s)
      ST_POWER_ON:        a = '{TO_MOTOR,   1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
      ST_IDLE:            a = '{TO_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      ST_PLUG_DETECT:     a = '{TO_NONE,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
      ST_LOCKING:         a = '{TO_MOTOR,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
      ST_LOCK_CHECK:      a = '{TO_NONE,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
      ST_CHARGING:        a = '{TO_NONE,    1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
      ST_POWER_LOST:      a = '{TO_NONE,    1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
      ST_UNLOCKING:       a = '{TO_MOTOR,   1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
      ST_UNLOCK_WAIT:     a = '{TO_RELEASE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
      ST_UNLOCKED:        a = '{TO_NONE,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
      ST_ERR_UNLOCK:      a = '{TO_MOTOR,   1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
      ST_ERR_UNLOCK_WAIT: a = '{TO_RELEASE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
      ST_ERR_UNLOCKED:    a = '{TO_NONE,    1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
      default:            a = '{TO_MOTOR,   1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    endcase
    return a;
  endfunction

  function automatic logic [CODE_W-1:0] code_of(state_t s);
    logic [CODE_W-1:0] c;
    case (s)
      ST_POWER_ON:        c = 4'd0;
      ST_IDLE:            c = 4'd1;
      ST_PLUG_DETECT:     c = 4'd2;
      ST_LOCKING:         c = 4'd3;
      ST_LOCK_CHECK:      c = 4'd4;
      ST_CHARGING:        c = 4'd5;
      ST_POWER_LOST:      c = 4'd6;
      ST_UNLOCKING:       c = 4'd7;
      ST_UNLOCK_WAIT:     c = 4'd8;
      ST_UNLOCKED:        c = 4'd9;
      ST_ERR_UNLOCK:      c = 4'd10;
      ST_ERR_UNLOCK_WAIT: c = 4'd11;
      ST_ERR_UNLOCKED:    c = 4'd12;
      default:            c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/cpls_if.sv]
// Interfaces: input item, result and configuration write channels.
interface cpls_item_if;
  import cpls_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cpls_result_if;
  import cpls_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cpls_cfg_if;
  import cpls_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/core/charge_port_lock_sequencer_core.sv]
// Top level: charge port lock sequencer with input register and result register.
//
//  channel  | dir | payload                                   | accepted when
//  ---------+-----+-------------------------------------------+----------------------
//  items    | in  | tick, has_cp, has_pp, lock_sense, unlock  | valid && ready
//  results  | out | state_code, changed, drives, lamps, flash | valid && ready
//  cfg      | in  | index, wdata (register write)             | valid && ready
//
// Each beat passes through the input register and then lands in the result
// register; one beat can be taken every cycle while the result register advances.
// The state and timer update in the same cycle as the result register loads.
// A stalled result register holds both stages once full; items.ready needs !in_valid or advance.
// Synchronous reset puts the port in power-on unlock with a cleared timer.
// cfg is always ready.
module charge_port_lock_sequencer_core (
  input  logic           clk,
  input  logic           rst,
  cpls_item_if.sink      items,
  cpls_result_if.source  results,
  cpls_cfg_if.sink       cfg
);
  import cpls_pkg::*;

  logic                   in_valid;
  item_t                  in_item;
  logic                   out_valid;
  result_t                out_data;
  state_t                 state;
  logic [TIMER_W-1:0]     timer;
  logic [TIMER_W-1:0]     motor_run_ticks;
  logic [TIMER_W-1:0]     release_wait_ticks;

  logic                   advance;
  logic                   fire;
  attr_t                  cur_attr;
  attr_t                  new_attr;
  logic [TIMER_W-1:0]     timer_tick;
  logic [TIMER_W-1:0]     limit;
  logic                   timed_out;
  logic                   cp_none;
  logic                   cp_one;
  logic                   cp_both;
  logic                   sense_locked;
  logic                   sense_unlocked;
  logic                   taken;
  state_t                 target;
  state_t                 state_next;
  logic [TIMER_W-1:0]     timer_next;
  result_t                out_data_next;

  assign advance       = !out_valid || results.ready;
  assign fire          = in_valid && advance;
  assign items.ready   = !in_valid || advance;
  assign cfg.ready     = 1'b1;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  assign cur_attr       = attr_of(state);
  assign timer_tick     = (in_item.tick && timer != TIMER_MAX) ? timer + 8'd1 : timer;
  assign cp_none        = !in_item.has_cp && !in_item.has_pp;
  assign cp_one         = in_item.has_cp != in_item.has_pp;
  assign cp_both        = in_item.has_cp && in_item.has_pp;
  assign sense_locked   = in_item.lock_sense == SENSE_LOCKED;
  assign sense_unlocked = in_item.lock_sense == SENSE_UNLOCKED;
  assign timed_out      = timer_tick >= limit;

  always_comb begin
    case (cur_attr.to_kind)
      TO_MOTOR:   limit = motor_run_ticks;
      TO_RELEASE: limit = release_wait_ticks;
      default:    limit = '0;
    endcase
  end

  // Transitions per state in fixed priority: switch, none, one, both,
  // locked, unlocked, timeout. Absent entries simply do not appear.
  always_comb begin
    taken  = 1'b0;
    target = state;
    case (state)
      ST_IDLE: begin
        if (cp_one) begin
          taken = 1'b1; target = ST_PLUG_DETECT;
        end else if (cp_both) begin
          taken = 1'b1; target = ST_LOCKING;
        end
      end
      ST_PLUG_DETECT: begin
        if (cp_none) begin
          taken = 1'b1; target = ST_IDLE;
        end else if (cp_both) begin
          taken = 1'b1; target = ST_LOCKING;
        end
      end
      ST_LOCKING: begin
        if (timed_out) begin
          taken = 1'b1; target = ST_LOCK_CHECK;
        end
      end
      ST_LOCK_CHECK: begin
        if (in_item.unlock_pressed) begin
          taken = 1'b1; target = ST_UNLOCKING;
        end else if (sense_locked) begin
          taken = 1'b1; target = ST_CHARGING;
        end else if (sense_unlocked) begin
          taken = 1'b1; target = ST_ERR_UNLOCK;
        end
      end
      ST_CHARGING: begin
        if (in_item.unlock_pressed) begin
          taken = 1'b1; target = ST_UNLOCKING;
        end else if (cp_none || cp_one) begin
          taken = 1'b1; target = ST_POWER_LOST;
        end
      end
      ST_POWER_LOST: begin
        if (in_item.unlock_pressed) begin
          taken = 1'b1; target = ST_UNLOCKING;
        end else if (cp_both) begin
          taken = 1'b1; target = ST_CHARGING;
        end
      end
      ST_UNLOCKING: begin
        if (timed_out) begin
          taken = 1'b1; target = ST_UNLOCK_WAIT;
        end
      end
      ST_UNLOCK_WAIT: begin
        if (in_item.unlock_pressed) begin
          taken = 1'b1; target = ST_UNLOCK_WAIT;
        end else if (timed_out) begin
          taken = 1'b1; target = ST_UNLOCKED;
        end
      end
      ST_UNLOCKED: begin
        if (in_item.unlock_pressed) begin
          taken = 1'b1; target = ST_UNLOCKING;
        end else if (cp_none) begin
          taken = 1'b1; target = ST_IDLE;
        end
      end
      ST_ERR_UNLOCK: begin
        if (timed_out) begin
          taken = 1'b1; target = ST_ERR_UNLOCK_WAIT;
        end
      end
      ST_ERR_UNLOCK_WAIT: begin
        if (in_item.unlock_pressed) begin
          taken = 1'b1; target = ST_ERR_UNLOCK_WAIT;
        end else if (timed_out) begin
          taken = 1'b1; target = ST_ERR_UNLOCKED;
        end
      end
      ST_ERR_UNLOCKED: begin
        if (in_item.unlock_pressed) begin
          taken = 1'b1; target = ST_ERR_UNLOCK;
        end else if (cp_none) begin
          taken = 1'b1; target = ST_IDLE;
        end
      end
      default: begin
        // Power-on unlock; also where an illegal vector would recover.
        if (timed_out) begin
          taken = 1'b1; target = ST_IDLE;
        end
      end
    endcase
  end

  assign state_next = taken ? target : state;
  assign timer_next = taken ? '0 : timer_tick;
  assign new_attr   = attr_of(state_next);

  always_comb begin
    out_data_next.state_code       = code_of(state_next);
    out_data_next.changed          = taken;
    out_data_next.inhibit_traction = new_attr.inhibit;
    out_data_next.motor_close      = new_attr.motor_close;
    out_data_next.motor_open       = new_attr.motor_open;
    out_data_next.charge_enable    = new_attr.charge;
    out_data_next.lamp_red         = new_attr.red;
    out_data_next.lamp_yellow      = new_attr.yellow;
    out_data_next.lamp_green       = new_attr.green;
    out_data_next.lamp_flash       = new_attr.flash;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid           <= 1'b0;
      out_valid          <= 1'b0;
      state              <= ST_POWER_ON;
      timer              <= '0;
      motor_run_ticks    <= MOTOR_RUN_RESET;
      release_wait_ticks <= RELEASE_WAIT_RESET;
    end else begin
      if (items.ready) begin
        in_valid <= items.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        state <= state_next;
        timer <= timer_next;
      end
      if (cfg.valid) begin
        case (cfg.index)
          REG_MOTOR_RUN:    motor_run_ticks    <= cfg.wdata;
          REG_RELEASE_WAIT: release_wait_ticks <= cfg.wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_item <= items.data;
    end
    if (fire) begin
      out_data <= out_data_next;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state vector is not one-hot");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.state_code == code_of(state))
    else $error("result state code disagrees with current state");

  a_taken_clears_timer: assert property (@(posedge clk) disable iff (rst)
    (fire && taken) |=> timer == '0)
    else $error("timer not cleared after a transition");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(timer) && $stable(state))
    else $error("state or timer moved without a beat");

endmodule
